// File: rtl/fmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpc_pkg
// Shared types and constants of the GF(2) minor parity checker.
// ----------------------------------------------------------------------------
package fmpc_pkg;
  localparam int unsigned MaxRank      = 8;
  localparam int unsigned MaxExtraCols = 8;
  localparam int unsigned ColW         = 4;

  typedef enum logic {
    REG_RANK   = 1'b0,
    REG_MATRIX = 1'b1
  } reg_idx_e;

  typedef logic [MaxRank-1:0] row_t;
  typedef row_t [MaxRank-1:0] mat_t;

  // Payload carried along the row of cells
  typedef struct packed {
    logic valid;
    logic singular;
    logic last;
    mat_t rows;
  } cell_bus_t;
endpackage

// File: rtl/fmpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpc_cell
// One elimination step: pivot on the column given by col_i, clear it below,
// register.
// ----------------------------------------------------------------------------
module fmpc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [2:0]        col_i,
  input  logic [3:0]        rank_i,
  input  fmpc_pkg::cell_bus_t bus_i,
  output fmpc_pkg::cell_bus_t bus_o
);
  import fmpc_pkg::*;

  cell_bus_t bus_d, bus_q;
  logic      found;
  logic [2:0] piv;
  row_t      prow;
  mat_t      sw;

  always_comb begin
    found = 1'b0;
    piv   = col_i;
    for (int p = MaxRank-1; p >= 0; p--) begin
      if (p >= int'(col_i) && p < int'(rank_i) && bus_i.rows[p][col_i]) begin
        found = 1'b1;
        piv   = 3'(p);
      end
    end
    prow = bus_i.rows[piv];
    sw   = bus_i.rows;
    sw[piv]   = bus_i.rows[col_i];
    sw[col_i] = prow;
    for (int i = 0; i < MaxRank; i++) begin
      if (i > int'(col_i) && sw[i][col_i]) sw[i] = sw[i] ^ prow;
    end
    bus_d.valid    = bus_i.valid;
    bus_d.last     = bus_i.last;
    bus_d.rows     = sw;
    // a column at or beyond the rank needs no pivot
    bus_d.singular = bus_i.singular | (({1'b0, col_i} < rank_i) & ~found);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
    end else if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign bus_o = bus_q;
endmodule

// File: rtl/facet_minor_parity_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facet_minor_parity_checker
// Determinant parity over GF(2) of minors of [I | A], with a running flag.
// ----------------------------------------------------------------------------
// Usage:
//   Write rank (index 0) and A (index 1) through cfg_we_i while idle.
//   Each s_axis transfer carries eight 4-bit column indices in tdata and
//   the last-facet marker in tlast. Each index below rank picks a unit
//   column, a larger one picks a column of A (zero when out of range).
//   The minor is built in one input stage, then passes a row of eight
//   elimination cells, one column pivot each, before its result leaves
//   on m_axis; one item per cycle is taken while the receiver does not stall.
//   The pipeline depth is the input stage plus one cell per minor column.
//   The running all-odd flag is kept at the output and restored to 1
//   after a result with tlast set.
//   A receiver stall freezes the whole row of cells (ready follows
//   m_axis_tready whenever the output holds a result), so nothing is lost.
//   Reset empties the pipeline, sets rank to 8, A to zero, the flag to 1.
// ----------------------------------------------------------------------------
module facet_minor_parity_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // col0 .. col7, 4 bits each
  input  logic        s_axis_tlast,   // last_facet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // minor_odd, all_odd, zero fill
  output logic        m_axis_tlast    // last_out
);
  import fmpc_pkg::*;

  logic [3:0]  rank_q, rank_eff;
  logic [63:0] mat_q;
  logic        all_q, all_d;
  logic        en;
  cell_bus_t   bus [MaxRank+1];
  cell_bus_t   in_d;
  cell_bus_t   in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= 4'd8;
      mat_q  <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RANK:   rank_q <= cfg_data_i[3:0];
        REG_MATRIX: mat_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    rank_eff = rank_q;
    if (rank_q == 4'd0) rank_eff = 4'd1;
    if (rank_q > 4'(MaxRank)) rank_eff = 4'(MaxRank);
  end

  // advance when the output is empty or being taken
  assign en            = ~bus[MaxRank].valid | m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    logic [3:0] k, e;
    in_d.valid    = s_axis_tvalid;
    in_d.last     = s_axis_tlast;
    in_d.singular = 1'b0;
    in_d.rows     = '0;
    for (int j = 0; j < MaxRank; j++) begin
      k = s_axis_tdata[j*ColW +: ColW];
      e = k - rank_eff;
      for (int i = 0; i < MaxRank; i++) begin
        if (i < int'(rank_eff) && j < int'(rank_eff)) begin
          if (k < rank_eff) in_d.rows[i][j] = (k == 4'(i));
          else if (e < 4'(MaxExtraCols)) in_d.rows[i][j] = mat_q[i*8 + int'(e[2:0])];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_q <= '0;
    else if (en) in_q <= in_d;
  end
  assign bus[0] = in_q;

  for (genvar c = 0; c < MaxRank; c++) begin : g_cell
    fmpc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .col_i  (3'(c)),
      .rank_i (rank_eff),
      .bus_i  (bus[c]),
      .bus_o  (bus[c+1])
    );
  end

  // running flag: update on each output transfer
  assign all_d = all_q & ~bus[MaxRank].singular;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) all_q <= 1'b1;
    else if (m_axis_tvalid && m_axis_tready) all_q <= bus[MaxRank].last ? 1'b1 : all_d;
  end

  assign m_axis_tvalid = bus[MaxRank].valid;
  assign m_axis_tdata  = {6'd0, all_d, ~bus[MaxRank].singular};
  assign m_axis_tlast  = bus[MaxRank].last;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pipeline blocked while output empty");
  a_flag_restore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> all_q)
    else $error("flag not restored after last facet");
endmodule
